FILE: src/fwsl_pkg.sv
package fwsl_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_POP    = 3'd1,
		CMD_HAS    = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [31:0] p;
		logic [31:0] o;
		logic [31:0] l;
	} req_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] piece_index;
		logic [31:0] block_offset;
		logic [31:0] block_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_piece_index;
		logic [31:0] out_block_offset;
		logic [31:0] out_block_length;
		logic [6:0]  entries_held;
	} out_item_t;

	// Operation broadcast to every cell in the update cycle.
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		req_t     key;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE    = 2'd0,
		S_COMPARE = 2'd1,
		S_UPDATE  = 2'd2
	} state_t;

	// Three-field unsigned compare, a before b.
	function automatic logic req_lt(req_t a, req_t b);
		if (a.p != b.p) return a.p < b.p;
		if (a.o != b.o) return a.o < b.o;
		return a.l < b.l;
	endfunction

endpackage

FILE: src/fwsl_sorted_cell.sv
// One slot of the sorted row. Inserts take the left neighbor's entry, deletes
// the right neighbor's, according to the registered compare flags.
module fwsl_sorted_cell (
	input  logic               clk,
	input  fwsl_pkg::cell_ctl_t ctl,
	input  logic               cmp_en,
	input  logic               valid,
	input  fwsl_pkg::req_t     left_entry,
	input  logic               left_lt,
	input  fwsl_pkg::req_t     right_entry,
	input  logic               first_eq,
	input  logic               left_first_eq_or_before,
	output fwsl_pkg::req_t     entry,
	output logic               lt_q,
	output logic               eq_q
);
	fwsl_pkg::req_t entry_q;

	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			lt_q <= fwsl_pkg::req_lt(entry_q, ctl.key);
			eq_q <= (entry_q == ctl.key);
		end
		case (ctl.op)
			fwsl_pkg::OP_INSERT: begin
				// Cells at or past the insert point move right by one. An empty
				// cell never counts as sorting before the key.
				if (!(lt_q && valid)) begin
					entry_q <= left_lt ? ctl.key : left_entry;
				end
			end
			fwsl_pkg::OP_DELETE: begin
				if (first_eq || left_first_eq_or_before) begin
					entry_q <= right_entry;
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: src/fwsl_arrival_cell.sv
// One slot of the arrival row. A delete at or left of this slot pulls in the
// right neighbor's entry.
module fwsl_arrival_cell (
	input  logic               clk,
	input  fwsl_pkg::cell_ctl_t ctl,
	input  logic               cmp_en,
	input  logic               write_here,
	input  fwsl_pkg::req_t     right_entry,
	input  logic               shift_here,
	output fwsl_pkg::req_t     entry,
	output logic               eq_q
);
	fwsl_pkg::req_t entry_q;

	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			eq_q <= (entry_q == ctl.key);
		end
		case (ctl.op)
			fwsl_pkg::OP_INSERT: if (write_here) entry_q <= ctl.key;
			fwsl_pkg::OP_DELETE: if (shift_here) entry_q <= right_entry;
			default: ;
		endcase
	end
endmodule

FILE: src/fifo_with_sorted_lookup_top.sv
// Channel   | Ports                        | Handshake
// ----------+------------------------------+-----------------------------
// command   | start, busy, cmd_in          | taken when start && !busy
// result    | done, result                 | one cycle strobe, no stall
//
// Every item passes the compare state, in which every cell of both rows
// compares its entry with the key, and the update state, in which the rows
// shift, before the registered result. busy is high during the compare and
// shift states and drops as the result is registered, so a new item is
// taken only once the previous one has passed both states.
// A pop first needs the oldest entry as its key; it is read straight from
// the head cell of the arrival row. Reset clears only the fill count and the
// control state; entry contents are left as they are. The receiver cannot
// stall, so a result is never held back.
module fifo_with_sorted_lookup_top #(
	parameter int CAPACITY = fwsl_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fwsl_pkg::in_item_t  cmd_in,
	output logic                done,
	output fwsl_pkg::out_item_t result
);
	localparam int CW = $clog2(CAPACITY + 1);

	fwsl_pkg::state_t state_q, state_d;
	logic [CW-1:0]    count_q;
	logic [2:0]       cmd_q;
	fwsl_pkg::req_t   key_q;
	fwsl_pkg::cell_ctl_t ctl;
	logic             cmp_en;

	fwsl_pkg::req_t s_entry [CAPACITY];
	logic           s_lt    [CAPACITY];
	logic           s_eq    [CAPACITY];
	fwsl_pkg::req_t a_entry [CAPACITY];
	logic           a_eq    [CAPACITY];

	// Valid-qualified flags: only cells below the fill count take part.
	logic [CAPACITY-1:0] s_valid, s_eqv, s_firsteq, s_before;
	logic [CAPACITY-1:0] a_eqv, a_before;
	logic                 any_eq, a_any;
	logic                 full;

	assign full   = (count_q == CW'(CAPACITY));
	assign busy   = (state_q != fwsl_pkg::S_IDLE);
	assign cmp_en = (state_q == fwsl_pkg::S_COMPARE);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			s_valid[i] = (CW'(i) < count_q);
			s_eqv[i]   = s_eq[i] && s_valid[i];
			a_eqv[i]   = a_eq[i] && s_valid[i];
		end
	end

	// Prefix marks: a cell is "before" once a match has been seen to its left.
	// The scan ripples one gate per cell.
	always_comb begin
		s_before[0] = 1'b0;
		a_before[0] = 1'b0;
		for (int i = 1; i < CAPACITY; i++) begin
			s_before[i] = s_before[i-1] || s_eqv[i-1];
			a_before[i] = a_before[i-1] || a_eqv[i-1];
		end
		for (int i = 0; i < CAPACITY; i++) begin
			s_firsteq[i] = s_eqv[i] && !s_before[i];
		end
		any_eq = |s_eqv;
		a_any  = |a_eqv;
	end

	// The op is decided in the compare result cycle.
	always_comb begin
		ctl.key = key_q;
		ctl.op  = fwsl_pkg::OP_NONE;
		if (state_q == fwsl_pkg::S_UPDATE) begin
			case (cmd_q)
				fwsl_pkg::CMD_APPEND: if (!full) ctl.op = fwsl_pkg::OP_INSERT;
				fwsl_pkg::CMD_POP:    if (count_q != '0) ctl.op = fwsl_pkg::OP_DELETE;
				fwsl_pkg::CMD_REMOVE: if (any_eq) ctl.op = fwsl_pkg::OP_DELETE;
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
		fwsl_pkg::req_t s_left, s_right, a_right;
		logic           s_left_lt, s_left_mark, a_shift, a_write;

		if (g == 0) begin : g_head
			assign s_left      = key_q;
			assign s_left_lt   = 1'b1;
			assign s_left_mark = 1'b0;
		end else begin : g_mid
			assign s_left      = s_entry[g-1];
			assign s_left_lt   = s_lt[g-1] && s_valid[g-1];
			assign s_left_mark = s_before[g];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign s_right = s_entry[g];
			assign a_right = a_entry[g];
		end else begin : g_inner
			assign s_right = s_entry[g+1];
			assign a_right = a_entry[g+1];
		end

		// Pop removes the head; remove drops the oldest match and shifts.
		assign a_shift = (cmd_q == fwsl_pkg::CMD_POP) ? 1'b1
		               : (a_any && (a_eqv[g] || a_before[g]));
		assign a_write = (CW'(g) == count_q);

		fwsl_sorted_cell u_s (
			.clk                     (clk),
			.ctl                     (ctl),
			.cmp_en                  (cmp_en),
			.valid                   (s_valid[g]),
			.left_entry              (s_left),
			.left_lt                 (s_left_lt),
			.right_entry             (s_right),
			.first_eq                (s_firsteq[g]),
			.left_first_eq_or_before (s_left_mark),
			.entry                   (s_entry[g]),
			.lt_q                    (s_lt[g]),
			.eq_q                    (s_eq[g])
		);

		fwsl_arrival_cell u_a (
			.clk         (clk),
			.ctl         (ctl),
			.cmp_en      (cmp_en),
			.write_here  (a_write),
			.right_entry (a_right),
			.shift_here  (a_shift),
			.entry       (a_entry[g]),
			.eq_q        (a_eq[g])
		);
	end

	// Invalid cells compare as "not before", so an insert lands at the fill
	// point. That needs lt forced low on cells past the count, both in the
	// left_lt path and through each sorted cell's own valid flag.

	always_comb begin
		state_d = state_q;
		case (state_q)
			fwsl_pkg::S_IDLE:    if (start) state_d = fwsl_pkg::S_COMPARE;
			fwsl_pkg::S_COMPARE: state_d = fwsl_pkg::S_UPDATE;
			fwsl_pkg::S_UPDATE:  state_d = fwsl_pkg::S_IDLE;
			default:             state_d = fwsl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwsl_pkg::S_IDLE;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == fwsl_pkg::S_UPDATE);
			if (state_q == fwsl_pkg::S_UPDATE) begin
				case (cmd_q)
					fwsl_pkg::CMD_APPEND: if (!full) count_q <= count_q + 1'b1;
					fwsl_pkg::CMD_POP:    if (count_q != '0) count_q <= count_q - 1'b1;
					fwsl_pkg::CMD_REMOVE: if (any_eq) count_q <= count_q - 1'b1;
					fwsl_pkg::CMD_CLEAR:  count_q <= '0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd_in.command;
			if (cmd_in.command == fwsl_pkg::CMD_POP) begin
				key_q <= a_entry[0];
			end else begin
				key_q <= '{p: cmd_in.piece_index, o: cmd_in.block_offset,
				           l: cmd_in.block_length};
			end
		end
		if (state_q == fwsl_pkg::S_UPDATE) begin
			result.out_piece_index  <= '0;
			result.out_block_offset <= '0;
			result.out_block_length <= '0;
			result.entries_held     <= 7'(count_q);
			case (cmd_q)
				fwsl_pkg::CMD_APPEND: begin
					result.status <= full ? fwsl_pkg::ST_FULL : fwsl_pkg::ST_OK;
					if (!full) result.entries_held <= 7'(count_q + 1'b1);
				end
				fwsl_pkg::CMD_POP: begin
					if (count_q == '0) begin
						result.status <= fwsl_pkg::ST_MISS;
					end else begin
						result.status           <= fwsl_pkg::ST_OK;
						result.out_piece_index  <= key_q.p;
						result.out_block_offset <= key_q.o;
						result.out_block_length <= key_q.l;
						result.entries_held     <= 7'(count_q - 1'b1);
					end
				end
				fwsl_pkg::CMD_HAS: result.status <= any_eq ? fwsl_pkg::ST_OK
				                                           : fwsl_pkg::ST_MISS;
				fwsl_pkg::CMD_REMOVE: begin
					result.status <= any_eq ? fwsl_pkg::ST_OK : fwsl_pkg::ST_MISS;
					if (any_eq) result.entries_held <= 7'(count_q - 1'b1);
				end
				fwsl_pkg::CMD_CLEAR: begin
					result.status       <= fwsl_pkg::ST_OK;
					result.entries_held <= '0;
				end
				default: result.status <= fwsl_pkg::ST_MISS;
			endcase
		end
	end

	// The fill count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("fill count past capacity");

	// A result strobe follows every accepted item.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done) else $error("missing result");

	// An append result is never reported full while room is left.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == fwsl_pkg::ST_FULL) |->
		result.entries_held == 7'(CAPACITY)) else $error("bad full status");
endmodule

FILE: tb/fifo_with_sorted_lookup_top_tb.sv
`timescale 1ns / 100ps

module fifo_with_sorted_lookup_top_tb;
	import fwsl_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t cmd_in;
	logic done;
	out_item_t result;

	fifo_with_sorted_lookup_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd_in(cmd_in),
		.done(done),
		.result(result)
	);

	// The predictor keeps its own copy of the table. The arrival row is a
	// queue, and the sorted row is a queue that is kept in ascending order.
	req_t arrival_row[$];
	req_t sorted_row[$];
	out_item_t expected_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit gaps_enabled = 1'b1;

	// A key compare that sorts by piece, offset, then length.
	function automatic bit key_before(req_t a, req_t b);
		return {a.p, a.o, a.l} < {b.p, b.o, b.l};
	endfunction

	// Works out the single result of one command and updates the table.
	function automatic out_item_t predict_command(in_item_t item);
		out_item_t res;
		req_t key;
		int pos;
		key = '{p: item.piece_index, o: item.block_offset, l: item.block_length};
		res = '0;
		res.status = ST_OK;
		case (item.command)
			CMD_APPEND: begin
				if (arrival_row.size() >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					// Lower bound: the new request goes before any equal entry.
					pos = 0;
					while (pos < sorted_row.size() && key_before(sorted_row[pos], key))
						pos++;
					sorted_row.insert(pos, key);
					arrival_row.push_back(key);
				end
			end
			CMD_POP: begin
				if (arrival_row.size() == 0) begin
					res.status = ST_MISS;
				end else begin
					key = arrival_row.pop_front();
					res.out_piece_index = key.p;
					res.out_block_offset = key.o;
					res.out_block_length = key.l;
					for (pos = 0; pos < sorted_row.size(); pos++)
						if (sorted_row[pos] == key) break;
					sorted_row.delete(pos);
				end
			end
			CMD_HAS: begin
				res.status = ST_MISS;
				foreach (sorted_row[i])
					if (sorted_row[i] == key) res.status = ST_OK;
			end
			CMD_REMOVE: begin
				res.status = ST_MISS;
				for (pos = 0; pos < sorted_row.size(); pos++)
					if (sorted_row[pos] == key) break;
				if (pos < sorted_row.size()) begin
					res.status = ST_OK;
					sorted_row.delete(pos);
					for (pos = 0; pos < arrival_row.size(); pos++)
						if (arrival_row[pos] == key) break;
					arrival_row.delete(pos);
				end
			end
			CMD_CLEAR: begin
				arrival_row.delete();
				sorted_row.delete();
			end
			default: begin
				// Unknown command codes leave the table as it is.
				res.status = ST_MISS;
			end
		endcase
		res.entries_held = 7'(arrival_row.size());
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The cycle counter guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Each result strobe is compared, field by field, with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(result.status), 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.out_piece_index !== want.out_piece_index)
					report_mismatch("out_piece_index", result.out_piece_index,
						want.out_piece_index);
				if (result.out_block_offset !== want.out_block_offset)
					report_mismatch("out_block_offset", result.out_block_offset,
						want.out_block_offset);
				if (result.out_block_length !== want.out_block_length)
					report_mismatch("out_block_length", result.out_block_length,
						want.out_block_length);
				if (result.entries_held !== want.entries_held)
					report_mismatch("entries_held", 32'(result.entries_held),
						32'(want.entries_held));
			end
		end
	end

	// Sends one item: holds start until the block takes it, then predicts.
	// A random gap of idle clocks may come first while gaps are enabled;
	// start stays high after acceptance so that the next item can follow at
	// once, and it is dropped during a gap or while waiting for results.
	task automatic send_item(logic [2:0] command, logic [31:0] piece, logic [31:0] offset,
			logic [31:0] length);
		in_item_t item;
		int gap;
		item = '{command: command, piece_index: piece, block_offset: offset,
			block_length: length};
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd_in <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(predict_command(item));
	endtask

	// Waits until every expected result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// A random request whose fields come from a small pool, so that equal
	// requests, hits and matches are common; sometimes fully random.
	function automatic req_t random_request();
		req_t r;
		if ($urandom_range(0, 9) == 0) begin
			r = '{p: $urandom, o: $urandom, l: $urandom};
		end else begin
			r.p = $urandom_range(0, 3);
			r.o = $urandom_range(0, 2) * 32'h4000;
			r.l = ($urandom_range(0, 1) == 0) ? 32'h4000 : 32'hFFFF_FFFF;
		end
		return r;
	endfunction

	// Pick a key that is held, if any, so presence and removal take the found path.
	function automatic req_t held_request();
		if (arrival_row.size() == 0) return random_request();
		return arrival_row[$urandom_range(0, arrival_row.size() - 1)];
	endfunction

	// Directed items: field extremes, every command, and the empty-table cases.
	task automatic test_directed();
		send_item(CMD_POP, 0, 0, 0);
		send_item(CMD_REMOVE, 1, 2, 3);
		send_item(CMD_HAS, 1, 2, 3);
		send_item(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_APPEND, 0, 0, 0);
		send_item(CMD_APPEND, 5, 7, 9);
		// An equal request goes ahead of its twin in sorted order.
		send_item(CMD_APPEND, 5, 7, 9);
		send_item(CMD_APPEND, 5, 7, 8);
		send_item(CMD_APPEND, 5, 6, 32'hFFFF_FFFF);
		send_item(CMD_APPEND, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_HAS, 5, 7, 9);
		send_item(CMD_HAS, 5, 7, 10);
		send_item(CMD_REMOVE, 5, 7, 9);
		send_item(CMD_REMOVE, 5, 7, 10);
		send_item(CMD_POP, 0, 0, 0);
		send_item(CMD_POP, 0, 0, 0);
		// Command codes past clear are ignored.
		send_item(3'd5, 1, 1, 1);
		send_item(3'd6, 0, 0, 0);
		send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_CLEAR, 0, 0, 0);
		send_item(CMD_POP, 0, 0, 0);
		drain_results();
	endtask

	// Fills the table to capacity, then appends once more to see the refusal.
	task automatic test_full_table();
		req_t r;
		while (arrival_row.size() < DEPTH) begin
			r = random_request();
			send_item(CMD_APPEND, r.p, r.o, r.l);
		end
		send_item(CMD_APPEND, 1, 1, 1);
		send_item(CMD_HAS, held_request().p, held_request().o, 0);
		r = held_request();
		send_item(CMD_REMOVE, r.p, r.o, r.l);
		send_item(CMD_APPEND, 2, 2, 2);
		send_item(CMD_APPEND, 3, 3, 3);
		// Empties the table by pops so the oldest ordering is checked all the way.
		while (arrival_row.size() > 0) send_item(CMD_POP, 0, 0, 0);
		send_item(CMD_POP, 0, 0, 0);
		drain_results();
	endtask

	// Random mix weighted toward appends and lookups of held requests.
	task automatic test_random_mix(int count, bit with_gaps);
		req_t r;
		int pick;
		gaps_enabled = with_gaps;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				r = random_request();
				send_item(CMD_APPEND, r.p, r.o, r.l);
			end else if (pick < 58) begin
				send_item(CMD_POP, $urandom, $urandom, $urandom);
			end else if (pick < 72) begin
				r = ($urandom_range(0, 1) == 0) ? held_request() : random_request();
				send_item(CMD_HAS, r.p, r.o, r.l);
			end else if (pick < 90) begin
				r = ($urandom_range(0, 2) != 0) ? held_request() : random_request();
				send_item(CMD_REMOVE, r.p, r.o, r.l);
			end else if (pick < 93) begin
				send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
			end else if (pick < 95) begin
				send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
			end else begin
				// A run of appends pushes the table up toward capacity.
				repeat ($urandom_range(10, 40)) begin
					r = random_request();
					send_item(CMD_APPEND, r.p, r.o, r.l);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd_in = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_random_mix(150, 1'b1);
		// The sender holds off here until every expected result has come.
		drain_results();
		test_random_mix(100, 1'b0);

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
